/* src/fqps_pkg.sv */
// Shared types and constants for the FASTQ position statistics block.
// No dependencies.
package fqps_pkg;

  localparam int unsigned DEF_MAX_READ_LENGTH = 512;
  localparam int unsigned DEF_COUNT_BITS      = 32;
  localparam int unsigned BASE_KINDS          = 5;
  localparam int unsigned WBITS               = 14;  // holds any index up to 16383
  localparam int unsigned QDEPTH              = 4;
  localparam int unsigned IN_DATA_BITS        = 24;
  localparam int unsigned OUT_DATA_BITS       = 336;

  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_N    = 8'h4e;
  localparam logic [7:0] CASE_MASK = 8'hdf;
  localparam logic [7:0] QUAL_NONE = 8'd255;

  typedef enum logic [1:0] {
    OP_FEED = 2'd0,
    OP_POS  = 2'd1,
    OP_GLOB = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_AT    = 3'd1,
    ST_NO_PLUS  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_Q_SHORT  = 3'd4,
    ST_Q_LONG   = 3'd5,
    ST_ODD_BASE = 3'd6,
    ST_HALTED   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SEQ    = 2'd1,
    PH_SEP    = 2'd2,
    PH_QUAL   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    BASE_A = 3'd0,
    BASE_T = 3'd1,
    BASE_G = 3'd2,
    BASE_C = 3'd3,
    BASE_N = 3'd4
  } base_t;

  // One classified word handed from front to back.
  typedef struct packed {
    op_t               kind;
    status_t           status;
    logic              base_we;
    base_t             base_kind;
    logic              len_we;
    logic              q_we;
    logic [7:0]        q_val;
    logic              pos_ok;
    logic              len_ok;
    logic [WBITS-1:0]  pos_addr;
    logic [WBITS-1:0]  len_addr;
    logic [31:0]       rec;
    logic [47:0]       bases;
    logic [7:0]        qlo;
    logic [7:0]        qhi;
  } cmd_t;

endpackage

/* src/fqps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fqps_front.sv */
// Front end: tracks the FASTQ record phase, checks format, keeps global
// counters and turns each input word into a command. Uses fqps_pkg.
module fqps_front #(
  parameter int unsigned MAX_READ_LENGTH = fqps_pkg::DEF_MAX_READ_LENGTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [9:0]       cfg_wr_data,
  input  logic             accept,
  input  logic [1:0]       op,
  input  logic [7:0]       text_byte,
  input  logic [9:0]       position,
  output fqps_pkg::cmd_t   cmd
);
  import fqps_pkg::*;

  localparam int unsigned OBITS = $clog2(MAX_READ_LENGTH + 2);
  localparam logic [WBITS-1:0] MAXW  = WBITS'(MAX_READ_LENGTH);
  localparam logic [WBITS-1:0] MAXW1 = WBITS'(MAX_READ_LENGTH + 1);

  phase_t           phase_r, phase_nxt;
  logic [OBITS-1:0] off_r, off_nxt;
  logic [OBITS-1:0] rlen_r, rlen_nxt;
  logic             qstop_r, qstop_nxt;
  logic             halted_r, halted_nxt;
  logic [31:0]      rec_r, rec_nxt;
  logic [47:0]      bases_r, bases_nxt;
  logic [7:0]       qlo_r, qlo_nxt;
  logic [7:0]       qhi_r, qhi_nxt;
  logic [9:0]       limit_r;

  logic [WBITS-1:0] off_w, rlen_w, lim_w, pos_w;
  logic [7:0]       folded, qv;
  logic             is_lf, head_bad, sep_bad, feed;

  assign off_w  = WBITS'(off_r);
  assign rlen_w = WBITS'(rlen_r);
  assign lim_w  = (WBITS'(limit_r) < MAXW) ? WBITS'(limit_r) : MAXW;
  assign pos_w  = WBITS'(position);
  assign folded = text_byte & CASE_MASK;
  assign qv     = text_byte - CH_BANG;
  assign is_lf  = (text_byte == CH_LF);
  assign head_bad = (off_r == '0) && (text_byte != CH_AT);
  assign sep_bad  = (off_r == '0) && (text_byte != CH_PLUS);
  assign feed   = accept && (op_t'(op) == OP_FEED) && !halted_r;

  // record phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (feed) begin
      unique case (phase_r)
        PH_HEADER: if (!head_bad && is_lf) phase_nxt = PH_SEQ;
        PH_SEQ:    if (is_lf) phase_nxt = PH_SEP;
        PH_SEP:    if (!sep_bad && is_lf) phase_nxt = PH_QUAL;
        PH_QUAL:   if (is_lf) phase_nxt = PH_HEADER;
        default:   phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    off_nxt    = off_r;
    rlen_nxt   = rlen_r;
    qstop_nxt  = qstop_r;
    halted_nxt = halted_r;
    rec_nxt    = rec_r;
    bases_nxt  = bases_r;
    qlo_nxt    = qlo_r;
    qhi_nxt    = qhi_r;

    cmd           = '0;
    cmd.kind      = op_t'(op);
    cmd.status    = halted_r ? ST_HALTED : ST_OK;
    cmd.pos_ok    = pos_w < MAXW;
    cmd.len_ok    = pos_w <= MAXW;
    cmd.pos_addr  = pos_w;
    cmd.len_addr  = pos_w;
    cmd.base_kind = BASE_N;
    cmd.rec       = rec_r;
    cmd.bases     = bases_r;
    cmd.qlo       = qlo_r;
    cmd.qhi       = qhi_r;

    if (feed) begin
      cmd.pos_addr = off_w;
      cmd.len_addr = off_w;
      unique case (phase_r)
        PH_HEADER: begin
          if (head_bad) begin
            halted_nxt = 1'b1;
            cmd.status = ST_NO_AT;
          end else if (is_lf) begin
            off_nxt = '0;
          end else if (off_w < MAXW1) begin
            off_nxt = off_r + 1'b1;
          end
        end
        PH_SEQ: begin
          if (is_lf) begin
            rlen_nxt   = off_r;
            cmd.len_we = 1'b1;
            bases_nxt  = bases_r + 48'(off_r);
            off_nxt    = '0;
          end else if (off_w >= lim_w) begin
            halted_nxt = 1'b1;
            cmd.status = ST_TOO_LONG;
          end else begin
            cmd.base_we = 1'b1;
            unique case (folded)
              CH_A:    cmd.base_kind = BASE_A;
              CH_T:    cmd.base_kind = BASE_T;
              CH_G:    cmd.base_kind = BASE_G;
              CH_C:    cmd.base_kind = BASE_C;
              CH_N:    cmd.base_kind = BASE_N;
              default: begin
                cmd.base_kind = BASE_N;
                cmd.status    = ST_ODD_BASE;
              end
            endcase
            off_nxt = off_r + 1'b1;
          end
        end
        PH_SEP: begin
          if (sep_bad) begin
            halted_nxt = 1'b1;
            cmd.status = ST_NO_PLUS;
          end else if (is_lf) begin
            off_nxt   = '0;
            qstop_nxt = 1'b0;
          end else if (off_w < MAXW1) begin
            off_nxt = off_r + 1'b1;
          end
        end
        PH_QUAL: begin
          if (is_lf) begin
            if (off_w < rlen_w)  cmd.status = ST_Q_SHORT;
            else if (qstop_r)    cmd.status = ST_Q_LONG;
            rec_nxt   = rec_r + 32'd1;
            off_nxt   = '0;
            qstop_nxt = 1'b0;
          end else begin
            if (off_w < rlen_w && off_w < MAXW) begin
              cmd.q_we  = 1'b1;
              cmd.q_val = qv;
              if (qv < qlo_r) qlo_nxt = qv;
              if (qv > qhi_r) qhi_nxt = qv;
            end else begin
              qstop_nxt = 1'b1;
            end
            if (off_w < MAXW1) off_nxt = off_r + 1'b1;
          end
        end
        default: cmd.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      rlen_r   <= '0;
      qstop_r  <= 1'b0;
      halted_r <= 1'b0;
      rec_r    <= '0;
      bases_r  <= '0;
      qlo_r    <= QUAL_NONE;
      qhi_r    <= '0;
      limit_r  <= 10'd512;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        off_r    <= off_nxt;
        rlen_r   <= rlen_nxt;
        qstop_r  <= qstop_nxt;
        halted_r <= halted_nxt;
        rec_r    <= rec_nxt;
        bases_r  <= bases_nxt;
        qlo_r    <= qlo_nxt;
        qhi_r    <= qhi_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

endmodule

/* src/fqps_queue.sv */
// Small FIFO of commands between front and back. Uses fqps_pkg.
module fqps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fqps_pkg::cmd_t push_data,
  input  logic           pop,
  output fqps_pkg::cmd_t head,
  output logic           not_empty,
  output logic           full
);
  import fqps_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  cmd_t          ent_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign head      = ent_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

/* src/fqps_back.sv */
// Back end: counter memories with read-modify-write and forwarding,
// clearing pass after reset, and the output register. Uses fqps_pkg, fqps_ram.
module fqps_back #(
  parameter int unsigned MAX_READ_LENGTH = fqps_pkg::DEF_MAX_READ_LENGTH,
  parameter int unsigned COUNT_BITS      = fqps_pkg::DEF_COUNT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fqps_pkg::cmd_t                        head,
  input  logic                                  head_valid,
  output logic                                  pop,
  output logic                                  clear_busy,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [fqps_pkg::OUT_DATA_BITS-1:0]    out_tdata
);
  import fqps_pkg::*;

  localparam int unsigned PBITS = MAX_READ_LENGTH > 1 ? $clog2(MAX_READ_LENGTH) : 1;
  localparam int unsigned LBITS = $clog2(MAX_READ_LENGTH + 1);
  localparam int unsigned QBITS = 40;

  logic             clearing_r;
  logic [LBITS-1:0] clr_r;
  logic             clr_pos;

  cmd_t s1_r;
  logic s1_v_r, s1_go;
  logic out_v_r;
  logic [OUT_DATA_BITS-1:0] out_d_r, out_d_nxt;

  logic [PBITS-1:0] s1_pa;
  logic [LBITS-1:0] s1_la;

  logic [COUNT_BITS-1:0] b_rd [BASE_KINDS];
  logic [COUNT_BITS-1:0] b_cur [BASE_KINDS];
  logic [COUNT_BITS-1:0] b_wd [BASE_KINDS];
  logic [BASE_KINDS-1:0] b_we;
  logic [COUNT_BITS-1:0] b_fd_r [BASE_KINDS];
  logic [PBITS-1:0]      b_fa_r [BASE_KINDS];
  logic [BASE_KINDS-1:0] b_fv_r;
  logic [BASE_KINDS-1:0] b_upd;

  logic [COUNT_BITS-1:0] l_rd, l_cur, l_fd_r;
  logic [LBITS-1:0]      l_fa_r;
  logic                  l_fv_r, l_upd;
  logic [QBITS-1:0]      q_rd, q_cur, q_fd_r;
  logic [PBITS-1:0]      q_fa_r;
  logic                  q_fv_r, q_upd;

  assign clear_busy = clearing_r;
  assign clr_pos    = WBITS'(clr_r) < WBITS'(MAX_READ_LENGTH);
  assign s1_go      = s1_v_r && (!out_v_r || out_tready);
  assign pop        = head_valid && !clearing_r && (!s1_v_r || s1_go);
  assign s1_pa      = s1_r.pos_addr[PBITS-1:0];
  assign s1_la      = s1_r.len_addr[LBITS-1:0];

  assign l_upd = s1_go && s1_r.len_we;
  assign q_upd = s1_go && s1_r.q_we;
  assign l_cur = (l_fv_r && l_fa_r == s1_la) ? l_fd_r : l_rd;
  assign q_cur = (q_fv_r && q_fa_r == s1_pa) ? q_fd_r : q_rd;

  for (genvar k = 0; k < BASE_KINDS; k++) begin : g_base
    assign b_upd[k] = s1_go && s1_r.base_we && (s1_r.base_kind == base_t'(k));
    assign b_cur[k] = (b_fv_r[k] && b_fa_r[k] == s1_pa) ? b_fd_r[k] : b_rd[k];
    assign b_we[k]  = clearing_r ? clr_pos : b_upd[k];
    assign b_wd[k]  = clearing_r ? '0 : b_cur[k] + 1'b1;

    fqps_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_READ_LENGTH)) u_base_ram (
      .clk   (clk),
      .we    (b_we[k]),
      .waddr (clearing_r ? clr_r[PBITS-1:0] : s1_pa),
      .wdata (b_wd[k]),
      .re    (pop),
      .raddr (head.pos_addr[PBITS-1:0]),
      .rdata (b_rd[k])
    );
  end

  fqps_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_READ_LENGTH + 1)) u_len_ram (
    .clk   (clk),
    .we    (clearing_r || l_upd),
    .waddr (clearing_r ? clr_r : s1_la),
    .wdata (clearing_r ? '0 : l_cur + 1'b1),
    .re    (pop),
    .raddr (head.len_addr[LBITS-1:0]),
    .rdata (l_rd)
  );

  fqps_ram #(.WIDTH(QBITS), .DEPTH(MAX_READ_LENGTH)) u_qual_ram (
    .clk   (clk),
    .we    (clearing_r ? clr_pos : q_upd),
    .waddr (clearing_r ? clr_r[PBITS-1:0] : s1_pa),
    .wdata (clearing_r ? '0 : q_cur + QBITS'(s1_r.q_val)),
    .re    (pop),
    .raddr (head.pos_addr[PBITS-1:0]),
    .rdata (q_rd)
  );

  // result word, fields from bit 0 up
  always_comb begin
    logic [31:0] ca, ct, cg, cc, cn, rol;
    logic [39:0] qt;
    logic [31:0] rec;
    logic [47:0] bases;
    logic [7:0]  qlo, qhi;
    ca = '0; ct = '0; cg = '0; cc = '0; cn = '0; rol = '0; qt = '0;
    rec = '0; bases = '0; qlo = '0; qhi = '0;
    unique case (s1_r.kind)
      OP_POS: begin
        if (s1_r.pos_ok) begin
          ca = 32'(b_cur[BASE_A]);
          ct = 32'(b_cur[BASE_T]);
          cg = 32'(b_cur[BASE_G]);
          cc = 32'(b_cur[BASE_C]);
          cn = 32'(b_cur[BASE_N]);
          qt = q_cur;
        end
        if (s1_r.len_ok) rol = 32'(l_cur);
      end
      OP_GLOB: begin
        rec   = s1_r.rec;
        bases = s1_r.bases;
        qlo   = s1_r.qlo;
        qhi   = s1_r.qhi;
      end
      default: rec = '0;
    endcase
    out_d_nxt = {5'd0, qt, rol, cn, cc, cg, ct, ca, qhi, qlo, bases, rec, s1_r.status};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  always_ff @(posedge clk) begin
    if (pop) s1_r <= head;
    if (s1_go) out_d_r <= out_d_nxt;
    for (int k = 0; k < BASE_KINDS; k++) begin
      if (b_upd[k]) begin
        b_fa_r[k] <= s1_pa;
        b_fd_r[k] <= b_wd[k];
      end
    end
    if (l_upd) begin
      l_fa_r <= s1_la;
      l_fd_r <= l_cur + 1'b1;
    end
    if (q_upd) begin
      q_fa_r <= s1_pa;
      q_fd_r <= q_cur + QBITS'(s1_r.q_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      b_fv_r     <= '0;
      l_fv_r     <= 1'b0;
      q_fv_r     <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (WBITS'(clr_r) == WBITS'(MAX_READ_LENGTH)) clearing_r <= 1'b0;
      end
      if (pop)        s1_v_r <= 1'b1;
      else if (s1_go) s1_v_r <= 1'b0;
      if (s1_go)           out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      b_fv_r <= b_fv_r | b_upd;
      if (l_upd) l_fv_r <= 1'b1;
      if (q_upd) q_fv_r <= 1'b1;
    end
  end

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !clearing_r |-> $onehot0(b_upd))
    else $error("more than one base counter updated");
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_v_r && !pop)
    else $error("command in flight during clearing pass");
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> s1_v_r)
    else $error("popped command lost");

endmodule

/* src/fastq_position_statistics.sv */
// FASTQ per-position statistics block, top level.
// Instantiates fqps_front, fqps_queue and fqps_back; uses fqps_pkg.
//
// Input words arrive on in_*: in_tuser carries the op (feed a text byte,
// read position statistics, read global statistics), in_tdata the byte
// and the position. Every accepted word yields exactly one result word on
// out_*, in order. cfg_wr_en/cfg_wr_data set the read length limit.
// Throughput is one word per cycle unless in_tready is low: each text byte
// does at most one counter read-modify-write in the back end, with the written
// value forwarded to the next word, so same-address bytes run back to back.
// From input accept to out_tvalid a word passes the queue write at the
// accepting edge, then the memory read stage and the output register.
// After reset the counter memories are zeroed by a clearing pass; in_tready
// stays low during it, configuration writes are taken. When the receiver
// stalls the output register holds, the back end stops, and the four-entry
// queue fills before in_tready drops.
module fastq_position_statistics #(
  parameter int unsigned MAX_READ_LENGTH = fqps_pkg::DEF_MAX_READ_LENGTH,
  parameter int unsigned COUNT_BITS      = fqps_pkg::DEF_COUNT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [9:0]                           cfg_wr_data,   // length_limit
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fqps_pkg::IN_DATA_BITS-1:0]    in_tdata,      // text_byte, position
  input  logic [1:0]                           in_tuser,      // op
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // status, record_count, total_bases, lowest_quality, highest_quality,
  // count_a, count_t, count_g, count_c, count_n, reads_of_length, quality_total
  output logic [fqps_pkg::OUT_DATA_BITS-1:0]   out_tdata
);
  import fqps_pkg::*;

  cmd_t cmd, head;
  logic accept, q_ne, q_full, pop, clear_busy;

  assign in_tready = !clear_busy && !q_full;
  assign accept    = in_tvalid && in_tready;

  fqps_front #(.MAX_READ_LENGTH(MAX_READ_LENGTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .op          (in_tuser),
    .text_byte   (in_tdata[7:0]),
    .position    (in_tdata[17:8]),
    .cmd         (cmd)
  );

  fqps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_ne),
    .full      (q_full)
  );

  fqps_back #(
    .MAX_READ_LENGTH (MAX_READ_LENGTH),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (q_ne),
    .pop        (pop),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/sv/fastq_position_statistics_test.sv */
// Testbench for fastq_position_statistics: streams FASTQ bytes and read-back ops,
// predicts every result word and checks each one whole, pad bits apart. Uses fqps_pkg.
module fastq_position_statistics_test;
  import fqps_pkg::*;

  typedef struct packed {
    logic [4:0]  pad;
    logic [39:0] quality_total;
    logic [31:0] reads_of_length;
    logic [31:0] count_n;
    logic [31:0] count_c;
    logic [31:0] count_g;
    logic [31:0] count_t;
    logic [31:0] count_a;
    logic [7:0]  highest_quality;
    logic [7:0]  lowest_quality;
    logic [47:0] total_bases;
    logic [31:0] record_count;
    status_t     status;
  } stats_word_t;

  typedef struct {
    op_t        op;
    logic [7:0] text;
    logic [9:0] pos;
    bit         known;
    status_t    st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [9:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;   // text_byte, position
  logic [1:0] in_tuser = '0;                // op
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;      // see stats_word_t, status lowest

  fastq_position_statistics i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  int unsigned lim_reg = 512;
  phase_t      cur_phase = PH_HEADER;
  int unsigned line_off = 0;
  int unsigned read_len = 0;
  bit          qual_over = 0;
  bit          stuck = 0;
  logic [31:0] rec_total = '0;
  logic [47:0] base_total = '0;
  logic [7:0]  qual_min = QUAL_NONE;
  logic [7:0]  qual_max = '0;
  logic [31:0] base_cnt [2560];
  logic [31:0] len_cnt [513];
  logic [39:0] qual_sum [512];

  stats_word_t pending_words[$];
  int fails = 0;
  int sent = 0;
  int send_idle = 0;
  int recv_stall = 0;

  function automatic status_t take_byte(logic [7:0] b);
    int unsigned lim;
    int unsigned k;
    logic [7:0] f;
    logic [7:0] q;
    status_t st;
    lim = (lim_reg < 512) ? lim_reg : 512;
    st = ST_OK;
    if (stuck) return ST_HALTED;
    case (cur_phase)
      PH_HEADER: begin
        if (line_off == 0 && b != CH_AT) begin
          stuck = 1;
          return ST_NO_AT;
        end
        if (b == CH_LF) begin
          cur_phase = PH_SEQ;
          line_off = 0;
        end else if (line_off < 513) line_off++;
      end
      PH_SEQ: begin
        if (b == CH_LF) begin
          read_len = line_off;
          if (read_len <= 512) len_cnt[read_len] = len_cnt[read_len] + 1;
          base_total = base_total + 48'(read_len);
          cur_phase = PH_SEP;
          line_off = 0;
        end else begin
          if (line_off >= lim) begin
            stuck = 1;
            return ST_TOO_LONG;
          end
          f = b & CASE_MASK;
          if (f == CH_A) k = BASE_A;
          else if (f == CH_T) k = BASE_T;
          else if (f == CH_G) k = BASE_G;
          else if (f == CH_C) k = BASE_C;
          else begin
            k = BASE_N;
            if (f != CH_N) st = ST_ODD_BASE;
          end
          base_cnt[line_off*5 + k] = base_cnt[line_off*5 + k] + 1;
          line_off++;
        end
      end
      PH_SEP: begin
        if (line_off == 0 && b != CH_PLUS) begin
          stuck = 1;
          return ST_NO_PLUS;
        end
        if (b == CH_LF) begin
          cur_phase = PH_QUAL;
          line_off = 0;
          qual_over = 0;
        end else if (line_off < 513) line_off++;
      end
      default: begin
        if (b == CH_LF) begin
          if (line_off < read_len) st = ST_Q_SHORT;
          else if (qual_over) st = ST_Q_LONG;
          rec_total = rec_total + 1;
          cur_phase = PH_HEADER;
          line_off = 0;
          qual_over = 0;
        end else begin
          if (line_off < read_len && line_off < 512) begin
            q = b - CH_BANG;
            if (q < qual_min) qual_min = q;
            if (q > qual_max) qual_max = q;
            qual_sum[line_off] = qual_sum[line_off] + 40'(q);
          end else qual_over = 1;
          if (line_off < 513) line_off++;
        end
      end
    endcase
    return st;
  endfunction

  function automatic stats_word_t predict_stats(op_t op, logic [7:0] b, logic [9:0] p);
    stats_word_t w;
    w = '0;
    if (op == OP_FEED) begin
      w.status = take_byte(b);
      return w;
    end
    w.status = stuck ? ST_HALTED : ST_OK;
    if (op == OP_POS) begin
      if (p < 512) begin
        w.count_a = base_cnt[p*5 + BASE_A];
        w.count_t = base_cnt[p*5 + BASE_T];
        w.count_g = base_cnt[p*5 + BASE_G];
        w.count_c = base_cnt[p*5 + BASE_C];
        w.count_n = base_cnt[p*5 + BASE_N];
        w.quality_total = qual_sum[p];
      end
      if (p <= 512) w.reads_of_length = len_cnt[p];
    end else if (op == OP_GLOB) begin
      w.record_count = rec_total;
      w.total_bases = base_total;
      w.lowest_quality = qual_min;
      w.highest_quality = qual_max;
    end
    return w;
  endfunction

  // hand one word over; the prediction is taken at the accepting edge
  task automatic send_word(op_t op, logic [7:0] b, logic [9:0] p, output status_t st);
    stats_word_t w;
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle) begin
        in_tvalid <= 1'b0;
        continue;
      end
      in_tvalid <= 1'b1;
      in_tuser <= op;
      in_tdata <= {6'b0, p, b};
      do @(posedge clk); while (!in_tready);
      w = predict_stats(op, b, p);
      pending_words = {pending_words, w};
      st = w.status;
      sent++;
      break;
    end
  endtask

  task automatic feed(logic [7:0] b);
    status_t st;
    send_word(OP_FEED, b, '0, st);
    // stray reads between bytes must not disturb the record tracking
    if ($urandom_range(99) < 8)
      send_word(op_t'($urandom_range(3) == 0 ? 3 : $urandom_range(1, 2)), 8'($urandom),
                10'($urandom_range(1023)), st);
  endtask

  function automatic logic [7:0] any_text();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_LF);
    return b;
  endfunction

  task automatic send_record(int len, int qlen);
    string bases;
    bases = "ACGTNacgtn";
    feed(CH_AT);
    repeat ($urandom_range(3)) feed(any_text());
    feed(CH_LF);
    repeat (len) feed($urandom_range(9) ? 8'(bases[$urandom_range(9)]) : any_text());
    feed(CH_LF);
    feed(CH_PLUS);
    repeat ($urandom_range(2)) feed(any_text());
    feed(CH_LF);
    repeat (qlen) feed($urandom_range(3) ? 8'($urandom_range(33, 74)) : any_text());
    feed(CH_LF);
  endtask

  task automatic drain_and_set(logic [9:0] lim);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    lim_reg = lim;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    stats_word_t got;
    stats_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = stats_word_t'(out_tdata);
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
        fails++;
      end else begin
        want = pending_words.pop_front();
        got.pad = '0;
        if (got !== want) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          fails++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t rows[] = '{
      '{OP_GLOB, 8'h00, 10'd0,    1, ST_OK},
      '{OP_POS,  8'hff, 10'd0,    1, ST_OK},
      '{OP_POS,  8'h00, 10'd512,  1, ST_OK},
      '{OP_POS,  8'h00, 10'd1023, 1, ST_OK},
      '{OP_NONE, 8'hff, 10'd1023, 1, ST_OK},
      '{OP_FEED, CH_AT, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_OK},
      '{OP_FEED, 8'h61, 10'd0, 1, ST_OK},
      '{OP_FEED, 8'h74, 10'd0, 1, ST_OK},
      '{OP_FEED, 8'h47, 10'd0, 1, ST_OK},
      '{OP_FEED, 8'h63, 10'd0, 1, ST_OK},
      '{OP_FEED, 8'h6e, 10'd0, 1, ST_OK},
      '{OP_FEED, 8'h78, 10'd0, 1, ST_ODD_BASE},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_PLUS, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_BANG, 10'd0, 0, ST_OK},
      '{OP_FEED, 8'hff, 10'd0, 0, ST_OK},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_Q_SHORT},
      '{OP_FEED, CH_AT, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_PLUS, 10'd0, 1, ST_OK},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_OK},
      '{OP_FEED, 8'h20, 10'd0, 0, ST_OK},
      '{OP_FEED, CH_LF, 10'd0, 1, ST_Q_LONG},
      '{OP_POS,  8'h00, 10'd0, 0, ST_OK},
      '{OP_GLOB, 8'h00, 10'd0, 0, ST_OK}
    };
    int unsigned lims[5] = '{1, 1023, 512, 0, 1};
    status_t st;
    int lim;
    int len;
    int qlen;

    foreach (base_cnt[i]) base_cnt[i] = '0;
    foreach (len_cnt[i]) len_cnt[i] = '0;
    foreach (qual_sum[i]) qual_sum[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_word(rows[i].op, rows[i].text, rows[i].pos, st);
      if (rows[i].known && st !== rows[i].st) begin
        $display("%0t: row %0d status, expected %0d, actual %0d", $time, i, rows[i].st, st);
        fails++;
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      lim = (lims[ph] == 0) ? $urandom_range(2, 40) : lims[ph];
      drain_and_set(10'(lim));
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 57; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 57; end
        3: begin send_idle = 14; recv_stall = 14; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (lim > 512) lim = 512;
      for (int goal = sent + 100; sent < goal; ) begin
        len = $urandom_range(lim < 20 ? lim : 20);
        qlen = len;
        if ($urandom_range(3) == 0) qlen = len + int'($urandom_range(4)) - 2;
        if (qlen < 0) qlen = 0;
        send_record(len, qlen);
      end
    end

    // one fatal format error, then everything reports the halt
    case ($urandom_range(2))
      0: feed($urandom_range(1) ? CH_LF : CH_PLUS);
      1: begin
        feed(CH_AT); feed(CH_LF); feed(8'h41); feed(CH_LF);
        feed($urandom_range(1) ? CH_LF : CH_AT);
      end
      default: begin
        feed(CH_AT); feed(CH_LF); feed(8'h43); feed(8'h47);
      end
    endcase
    repeat (4) send_word(OP_FEED, CH_AT, '0, st);
    send_word(OP_POS, '0, 10'd0, st);
    send_word(OP_GLOB, '0, 10'd0, st);
    send_word(OP_NONE, '0, 10'd0, st);

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (10) @(posedge clk);
    if (pending_words.size() != 0) fails++;
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
